/* hdl/stsc_pkg.sv */
// stsc_pkg: shared constants, token tables and types for the source token scanner
// no dependencies; imported by every module of the scanner
package stsc_pkg;

   localparam int STSC_MAX_LEN = 4095;
   localparam int HEAD_BYTES   = 8;
   localparam int HEAD_W       = HEAD_BYTES * 8;
   localparam int HIDX_W       = $clog2(HEAD_BYTES);
   localparam int KIND_W       = 6;

   localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd10;
   localparam logic [KIND_W-1:0] KIND_INT     = 6'd11;
   localparam logic [KIND_W-1:0] KIND_FLOAT   = 6'd12;
   localparam logic [KIND_W-1:0] KIND_OP_BASE = 6'd13;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 6'd36;

   // token dfa states
   localparam logic [2:0] LX_EMPTY = 3'd0;
   localparam logic [2:0] LX_IDENT = 3'd1;
   localparam logic [2:0] LX_INT   = 3'd2;
   localparam logic [2:0] LX_FLOAT = 3'd3;
   localparam logic [2:0] LX_OP    = 3'd4;

   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_STAR    = 8'h2a;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_UNDER   = 8'h5f;
   localparam logic [7:0] CH_LOW_E   = 8'h65;
   localparam logic [7:0] CH_UP_E    = 8'h45;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_EQ      = 8'h3d;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_LT      = 8'h3c;
   localparam logic [7:0] CH_GT      = 8'h3e;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_BAR     = 8'h7c;

   // keyword text, first byte in the low octet
   localparam int KW_NUM = 10;
   localparam logic [HEAD_W-1:0] KW_TEXT [KW_NUM] = '{
      64'h0000_0074_736e_6f63,   // const
      64'h0000_0000_0074_6e69,   // int
      64'h0000_0074_616f_6c66,   // float
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_6573_6c65,   // else
      64'h0000_0065_6c69_6877,   // while
      64'h6575_6e69_746e_6f63,   // continue
      64'h0000_006b_6165_7262,   // break
      64'h0000_6e72_7574_6572,   // return
      64'h0000_0000_6469_6f76    // void
   };
   localparam logic [3:0] KW_LEN [KW_NUM] = '{
      4'd5, 4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd8, 4'd5, 4'd6, 4'd4
   };

   localparam int OP_NUM = 23;
   localparam logic [15:0] OP_TEXT [OP_NUM] = '{
      16'h002b, 16'h002d, 16'h002a, 16'h002f, 16'h0025, 16'h003c, 16'h3d3c,
      16'h003e, 16'h3d3e, 16'h3d3d, 16'h3d21, 16'h003d, 16'h0021, 16'h2626,
      16'h7c7c, 16'h003b, 16'h002c, 16'h0028, 16'h0029, 16'h005b, 16'h005d,
      16'h007b, 16'h007d
   };
   localparam logic [1:0] OP_LEN [OP_NUM] = '{
      2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1,
      2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
   };

   // up to two lexer steps per input word: a released slash and the byte after it,
   // or a released slash and the end flush
   typedef struct packed {
      logic       a_valid;
      logic [7:0] a_ch;
      logic       b_valid;
      logic       b_flush;
      logic [7:0] b_ch;
   } filt_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h00 || c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
   endfunction

endpackage

/* hdl/source_token_scanner.sv */
// source_token_scanner: top level, input register, lexer state and the two dfa steps
// depends on stsc_pkg, stsc_filter, stsc_lex_step and stsc_rsp_buf
//
// Takes one source byte (or an end command) per word on req_ and returns tokens on
// rsp_ as kind, saturating length and the first eight bytes. Comments are stripped
// before tokenizing; end flushes the pending token and returns the scanner to its
// reset state. A word is accepted every cycle unless rsp_stall holds the result
// register or a second token waits, and its first token is valid on rsp_ once it
// has moved from the input register into the result register. A word gives zero,
// one or two tokens; the second token of a word waits in an extra slot, and until
// it moves up into the result register the next word waits in the input register.
// rsp_last marks the final token of a word.
module source_token_scanner import stsc_pkg::*; #(
   parameter int MAX_LEN = STSC_MAX_LEN,
   parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic [7:0]        req_ch,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_token_kind,
   output logic [LEN_W-1:0]  rsp_token_length,
   output logic [HEAD_W-1:0] rsp_token_head,
   output logic              rsp_last
);

   logic              in_valid_ff, in_valid_in;
   logic              in_cmd_ff, in_cmd_in;
   logic [7:0]        in_ch_ff, in_ch_in;
   logic [2:0]        mode_ff, mode_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [7:0]        prev_ff, prev_in;

   logic              go, free;
   filt_type          filt;

   logic [2:0]        a_mode;
   logic [LEN_W-1:0]  a_len, a_tok_len, b_tok_len;
   logic [HEAD_W-1:0] a_head, a_tok_head, b_tok_head;
   logic [7:0]        a_prev;
   logic              a_emit, b_emit;
   logic [KIND_W-1:0] a_kind, b_kind;

   assign go        = in_valid_ff && free;
   assign req_stall = in_valid_ff && !go;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_cmd_in   = in_cmd_ff;
      in_ch_in    = in_ch_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_cmd_in   = req_cmd;
         in_ch_in    = req_ch;
      end
   end

   stsc_filter u_filter (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .cmd   (in_cmd_ff),
      .ch    (in_ch_ff),
      .filt  (filt)
   );

   stsc_lex_step #(.MAX_LEN(MAX_LEN), .LEN_W(LEN_W)) u_step_a (
      .valid      (filt.a_valid),
      .flush      (1'b0),
      .ch         (filt.a_ch),
      .mode_i     (mode_ff),
      .len_i      (len_ff),
      .head_i     (head_ff),
      .prev_i     (prev_ff),
      .mode_o     (a_mode),
      .len_o      (a_len),
      .head_o     (a_head),
      .prev_o     (a_prev),
      .emit_o     (a_emit),
      .kind_o     (a_kind),
      .tok_len_o  (a_tok_len),
      .tok_head_o (a_tok_head)
   );

   stsc_lex_step #(.MAX_LEN(MAX_LEN), .LEN_W(LEN_W)) u_step_b (
      .valid      (filt.b_valid),
      .flush      (filt.b_flush),
      .ch         (filt.b_ch),
      .mode_i     (a_mode),
      .len_i      (a_len),
      .head_i     (a_head),
      .prev_i     (a_prev),
      .mode_o     (mode_in),
      .len_o      (len_in),
      .head_o     (head_in),
      .prev_o     (prev_in),
      .emit_o     (b_emit),
      .kind_o     (b_kind),
      .tok_len_o  (b_tok_len),
      .tok_head_o (b_tok_head)
   );

   stsc_rsp_buf #(.LEN_W(LEN_W)) u_rsp_buf (
      .clock            (clock),
      .reset            (reset),
      .p0_valid         (go && (a_emit || b_emit)),
      .p0_kind          (a_emit ? a_kind : b_kind),
      .p0_len           (a_emit ? a_tok_len : b_tok_len),
      .p0_head          (a_emit ? a_tok_head : b_tok_head),
      .p1_valid         (go && a_emit && b_emit),
      .p1_kind          (b_kind),
      .p1_len           (b_tok_len),
      .p1_head          (b_tok_head),
      .free             (free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_length (rsp_token_length),
      .rsp_token_head   (rsp_token_head),
      .rsp_last         (rsp_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= LX_EMPTY;
         len_ff      <= '0;
         head_ff     <= '0;
         prev_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (go) begin
            mode_ff <= mode_in;
            len_ff  <= len_in;
            head_ff <= head_in;
            prev_ff <= prev_in;
         end
      end
      in_cmd_ff <= in_cmd_in;
      in_ch_ff  <= in_ch_in;
   end

endmodule

/* hdl/stsc_filter.sv */
// stsc_filter: comment stripping front end, holds the comment mode register
// depends on stsc_pkg
module stsc_filter import stsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic       cmd,
   input  logic [7:0] ch,
   output filt_type   filt
);

   localparam logic [2:0] CM_NORMAL    = 3'd0;
   localparam logic [2:0] CM_SLASH     = 3'd1;
   localparam logic [2:0] CM_BLOCK     = 3'd2;
   localparam logic [2:0] CM_MAYBE_END = 3'd3;
   localparam logic [2:0] CM_LINE      = 3'd4;

   logic [2:0] cm_ff, cm_in;

   always_comb begin
      filt         = '0;
      filt.a_ch    = ch;
      filt.b_ch    = ch;
      cm_in        = cm_ff;
      if (cmd) begin
         // release a held slash, then flush the pending token
         filt.a_valid = (cm_ff == CM_SLASH);
         filt.a_ch    = CH_SLASH;
         filt.b_valid = 1'b1;
         filt.b_flush = 1'b1;
         cm_in        = CM_NORMAL;
      end else begin
         unique case (cm_ff)
            CM_SLASH: begin
               if (ch == CH_STAR) begin
                  cm_in = CM_BLOCK;
               end else if (ch == CH_SLASH) begin
                  cm_in = CM_LINE;
               end else begin
                  cm_in        = CM_NORMAL;
                  filt.a_valid = 1'b1;
                  filt.a_ch    = CH_SLASH;
                  filt.b_valid = 1'b1;
               end
            end
            CM_BLOCK: begin
               if (ch == CH_STAR) cm_in = CM_MAYBE_END;
            end
            CM_MAYBE_END: begin
               if (ch == CH_SLASH) cm_in = CM_NORMAL;
               else if (ch != CH_STAR) cm_in = CM_BLOCK;
            end
            CM_LINE: begin
               if (ch == CH_NEWLINE) begin
                  cm_in        = CM_NORMAL;
                  filt.a_valid = 1'b1;
               end
            end
            default: begin
               cm_in = CM_NORMAL;
               if (ch == CH_SLASH) cm_in = CM_SLASH;
               else filt.a_valid = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cm_ff <= CM_NORMAL;
      end else if (go) begin
         cm_ff <= cm_in;
      end
   end

endmodule

/* hdl/stsc_lex_step.sv */
// stsc_lex_step: one byte step of the token dfa with keyword and operator lookup
// depends on stsc_pkg; purely combinational, state lives in the top level
module stsc_lex_step import stsc_pkg::*; #(
   parameter int MAX_LEN = STSC_MAX_LEN,
   parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
   input  logic              valid,
   input  logic              flush,
   input  logic [7:0]        ch,
   input  logic [2:0]        mode_i,
   input  logic [LEN_W-1:0]  len_i,
   input  logic [HEAD_W-1:0] head_i,
   input  logic [7:0]        prev_i,
   output logic [2:0]        mode_o,
   output logic [LEN_W-1:0]  len_o,
   output logic [HEAD_W-1:0] head_o,
   output logic [7:0]        prev_o,
   output logic              emit_o,
   output logic [KIND_W-1:0] kind_o,
   output logic [LEN_W-1:0]  tok_len_o,
   output logic [HEAD_W-1:0] tok_head_o
);

   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_LEN);
   localparam logic [LEN_W-1:0] LEN_HEAD = LEN_W'(HEAD_BYTES);
   localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

   logic              c_alpha, c_digit, c_space, c_sign;
   logic [LEN_W-1:0]  app_len;
   logic [HEAD_W-1:0] app_head;
   logic [2:0]        st_mode;
   logic              ext, dbl, close;
   logic [2:0]        ext_mode;
   logic [7:0]        first;

   assign c_alpha = is_alpha(ch);
   assign c_digit = is_digit(ch);
   assign c_space = is_space(ch);
   assign c_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign first   = head_i[7:0];

   // append the byte to the pending token
   always_comb begin
      app_len  = (len_i < LEN_MAX) ? len_i + LEN_ONE : len_i;
      app_head = head_i;
      if (len_i < LEN_HEAD) begin
         for (int i = 0; i < HEAD_BYTES; i++) begin
            if (len_i[HIDX_W-1:0] == HIDX_W'(i)) app_head[i*8 +: 8] = ch;
         end
      end
   end

   // token started by this byte from a cleared state
   always_comb begin
      if (c_alpha || ch == CH_UNDER) st_mode = LX_IDENT;
      else if (c_digit) st_mode = LX_INT;
      else if (ch == CH_DOT) st_mode = LX_FLOAT;
      else if (!c_space) st_mode = LX_OP;
      else st_mode = LX_EMPTY;
   end

   always_comb begin
      ext      = 1'b0;
      dbl      = 1'b0;
      close    = 1'b0;
      ext_mode = mode_i;
      unique case (mode_i)
         LX_IDENT: begin
            if (c_alpha || c_digit || ch == CH_UNDER) ext = 1'b1;
            else close = 1'b1;
         end
         LX_INT: begin
            if (ch == CH_DOT) begin
               ext      = 1'b1;
               ext_mode = LX_FLOAT;
            end else if (c_digit || c_alpha) begin
               ext = 1'b1;
            end else if ((prev_i == CH_LOW_E || prev_i == CH_UP_E) && c_sign) begin
               ext      = 1'b1;
               ext_mode = LX_FLOAT;
            end else begin
               close = 1'b1;
            end
         end
         LX_FLOAT: begin
            if (c_digit || c_alpha) ext = 1'b1;
            else if (c_sign && is_alpha(prev_i)) ext = 1'b1;
            else close = 1'b1;
         end
         LX_OP: begin
            if (len_i == LEN_ONE &&
                ((ch == CH_EQ && (first == CH_EQ || first == CH_BANG ||
                                  first == CH_LT || first == CH_GT)) ||
                 (ch == CH_AMP && first == CH_AMP) || (ch == CH_BAR && first == CH_BAR))) begin
               dbl = 1'b1;
            end else begin
               close = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      mode_o     = mode_i;
      len_o      = len_i;
      head_o     = head_i;
      prev_o     = prev_i;
      emit_o     = 1'b0;
      tok_len_o  = len_i;
      tok_head_o = head_i;
      if (valid) begin
         if (flush) begin
            emit_o = (len_i != '0);
            mode_o = LX_EMPTY;
            len_o  = '0;
            head_o = '0;
            prev_o = '0;
         end else if (ext) begin
            mode_o = ext_mode;
            len_o  = app_len;
            head_o = app_head;
            prev_o = ch;
         end else if (dbl) begin
            emit_o     = 1'b1;
            tok_len_o  = app_len;
            tok_head_o = app_head;
            mode_o     = LX_EMPTY;
            len_o      = '0;
            head_o     = '0;
            prev_o     = '0;
         end else begin
            // closing byte is scanned again from the empty state
            emit_o = close;
            mode_o = st_mode;
            if (st_mode != LX_EMPTY) begin
               len_o  = LEN_ONE;
               head_o = {{(HEAD_W-8){1'b0}}, ch};
               prev_o = ch;
            end else begin
               len_o  = '0;
               head_o = '0;
               prev_o = '0;
            end
         end
      end
   end

   always_comb begin
      if (mode_i == LX_IDENT) begin
         kind_o = KIND_IDENT;
         for (int i = KW_NUM - 1; i >= 0; i--) begin
            if (tok_len_o == LEN_W'(KW_LEN[i]) && tok_head_o == KW_TEXT[i]) begin
               kind_o = KIND_W'(i);
            end
         end
      end else if (mode_i == LX_INT) begin
         kind_o = KIND_INT;
      end else if (mode_i == LX_FLOAT) begin
         kind_o = KIND_FLOAT;
      end else begin
         kind_o = KIND_UNKNOWN;
         for (int i = OP_NUM - 1; i >= 0; i--) begin
            if (tok_len_o == LEN_W'(OP_LEN[i]) && tok_head_o[HEAD_W-1:16] == '0 &&
                tok_head_o[15:0] == OP_TEXT[i]) begin
               kind_o = KIND_OP_BASE + KIND_W'(i);
            end
         end
      end
   end

endmodule

/* hdl/stsc_rsp_buf.sv */
// stsc_rsp_buf: result register plus one extra slot for a second token of a word
// depends on stsc_pkg
module stsc_rsp_buf import stsc_pkg::*; #(
   parameter int LEN_W = $clog2(STSC_MAX_LEN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              p0_valid,
   input  logic [KIND_W-1:0] p0_kind,
   input  logic [LEN_W-1:0]  p0_len,
   input  logic [HEAD_W-1:0] p0_head,
   input  logic              p1_valid,
   input  logic [KIND_W-1:0] p1_kind,
   input  logic [LEN_W-1:0]  p1_len,
   input  logic [HEAD_W-1:0] p1_head,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_token_kind,
   output logic [LEN_W-1:0]  rsp_token_length,
   output logic [HEAD_W-1:0] rsp_token_head,
   output logic              rsp_last
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [HEAD_W-1:0] rsp_head_ff, rsp_head_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              x_valid_ff, x_valid_in;
   logic [KIND_W-1:0] x_kind_ff, x_kind_in;
   logic [LEN_W-1:0]  x_len_ff, x_len_in;
   logic [HEAD_W-1:0] x_head_ff, x_head_in;
   logic              open;

   assign open = !rsp_valid_ff || !rsp_stall;
   assign free = open && !x_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_head_in  = rsp_head_ff;
      rsp_last_in  = rsp_last_ff;
      x_valid_in   = x_valid_ff;
      x_kind_in    = x_kind_ff;
      x_len_in     = x_len_ff;
      x_head_in    = x_head_ff;
      if (p0_valid) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = p0_kind;
         rsp_len_in   = p0_len;
         rsp_head_in  = p0_head;
         rsp_last_in  = !p1_valid;
         if (p1_valid) begin
            x_valid_in = 1'b1;
            x_kind_in  = p1_kind;
            x_len_in   = p1_len;
            x_head_in  = p1_head;
         end
      end else if (x_valid_ff && open) begin
         // second token of the word moves up, it is always the final one
         rsp_valid_in = 1'b1;
         rsp_kind_in  = x_kind_ff;
         rsp_len_in   = x_len_ff;
         rsp_head_in  = x_head_ff;
         rsp_last_in  = 1'b1;
         x_valid_in   = 1'b0;
      end else if (open) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         x_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         x_valid_ff   <= x_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_head_ff <= rsp_head_in;
      rsp_last_ff <= rsp_last_in;
      x_kind_ff   <= x_kind_in;
      x_len_ff    <= x_len_in;
      x_head_ff   <= x_head_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_kind   = rsp_kind_ff;
   assign rsp_token_length = rsp_len_ff;
   assign rsp_token_head   = rsp_head_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
